// ----- hw/rtl/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int TIME_BITS  = 16;
  localparam int PRIO_BITS  = 8;
  localparam int SLOT_BITS  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int COUNT_BITS = $clog2(MAX_PROCS + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_LOADED = 2'd0;
  localparam logic [1:0] ST_RAN    = 2'd1;
  localparam logic [1:0] ST_IDLE   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic                 opcode;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] burst_length;
    logic [PRIO_BITS-1:0] priority_level;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] process_number;
    logic                  finished;
    logic [TIME_BITS-1:0]  time_now;
    logic [TIME_BITS-1:0]  start_time;
    logic [TIME_BITS-1:0]  completion_time;
    logic [TIME_BITS-1:0]  turnaround_time;
    logic [TIME_BITS-1:0]  waiting_time;
    logic [TIME_BITS-1:0]  response_time;
  } res_t;

  // One process table entry, as held in the RAM.
  typedef struct packed {
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [PRIO_BITS-1:0] prio;
    logic [TIME_BITS-1:0] remaining;
    logic [TIME_BITS-1:0] start;
    logic                 done;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ----- hw/rtl/pps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler: process table in one RAM, scanned per tick.
// Depends on pps_pkg and pps_ram.
`timescale 1ns / 1ps
// Load word: result strobed the cycle after acceptance, busy stays low, so
//   loads can follow back to back.
// Tick word: S_SCAN issues one RAM read per loaded entry through the single
//   read port and takes in the last read data, then S_UPD writes the chosen
//   entry back and registers the result.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Synchronous active-high reset clears the entry count, time and sequencer.

module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state;

  logic [COUNT_BITS-1:0] loaded_count;
  logic [TIME_BITS-1:0]  current_time;
  logic [TIME_BITS-1:0]  time_adv;

  // Scan bookkeeping: iss is the next slot to read, pend marks read data due.
  logic [COUNT_BITS-1:0] iss;
  logic                  pend;
  logic [SLOT_BITS-1:0]  pend_idx;

  // Best candidate so far, held as a full entry so no re-read is needed.
  logic                  found;
  logic [SLOT_BITS-1:0]  best_idx;
  entry_t                best;

  // RAM ports
  logic                  wr_en;
  logic [SLOT_BITS-1:0]  wr_addr;
  entry_t                wr_data;
  logic                  rd_en;
  entry_t                rd_data;

  logic accept;
  logic full;
  logic ready_cand;
  logic better;
  logic scan_last;

  // Write-back figures for the chosen process
  logic [TIME_BITS-1:0] rem_next;
  logic [TIME_BITS-1:0] start_next;
  logic                 fin;
  logic [TIME_BITS-1:0] turnaround;
  logic [TIME_BITS-1:0] waiting;
  logic [TIME_BITS-1:0] response;

  res_t result_next;

  assign busy   = !state[0];
  assign accept = start && !busy;
  assign full   = (loaded_count == COUNT_BITS'(MAX_PROCS));

  // Time saturates at all ones
  assign time_adv = (current_time == '1) ? current_time : current_time + 1'b1;

  pps_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss[SLOT_BITS-1:0]),
    .rd_data (rd_data)
  );

  // Scan compare: strict compares keep the lower slot on a full tie.
  assign rd_en      = (state == S_SCAN) && (iss < loaded_count);
  assign scan_last  = (iss >= loaded_count);
  assign ready_cand = pend && !rd_data.done && (rd_data.arrival <= current_time);
  assign better     = !found || (rd_data.prio > best.prio) ||
                      ((rd_data.prio == best.prio) && (rd_data.arrival < best.arrival));

  // Run one unit of the chosen process
  always_comb begin
    rem_next   = (best.remaining != '0) ? best.remaining - 1'b1 : best.remaining;
    start_next = (best.remaining == best.burst) ? current_time : best.start;
    fin        = (rem_next == '0);
    turnaround = (time_adv >= best.arrival) ? time_adv - best.arrival : '0;
    waiting    = (turnaround >= best.burst) ? turnaround - best.burst : '0;
    response   = (start_next >= best.arrival) ? start_next - best.arrival : '0;
  end

  // RAM write: a load in idle, or the write-back after a scan
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = best;
    if (state == S_IDLE) begin
      wr_en             = accept && (cmd.opcode == OP_LOAD) && !full;
      wr_addr           = loaded_count[SLOT_BITS-1:0];
      wr_data.arrival   = cmd.arrival_time;
      wr_data.burst     = cmd.burst_length;
      wr_data.prio      = cmd.priority_level;
      wr_data.remaining = cmd.burst_length;
      wr_data.start     = '0;
      wr_data.done      = 1'b0;
    end else if (state == S_UPD) begin
      wr_en             = found;
      wr_data.remaining = rem_next;
      wr_data.start     = start_next;
      wr_data.done      = fin;
    end
  end

  // Result word
  always_comb begin
    result_next = '0;
    if (state == S_IDLE) begin
      result_next.time_now = current_time;
      if (full) begin
        result_next.status = ST_FULL;
      end else begin
        result_next.status         = ST_LOADED;
        result_next.process_number = loaded_count + 1'b1;
      end
    end else begin
      result_next.time_now = time_adv;
      if (!found) begin
        result_next.status = ST_IDLE;
      end else begin
        result_next.status         = ST_RAN;
        result_next.process_number = COUNT_BITS'(best_idx) + COUNT_BITS'(1);
        result_next.finished       = fin;
        if (fin) begin
          result_next.start_time      = start_next;
          result_next.completion_time = time_adv;
          result_next.turnaround_time = turnaround;
          result_next.waiting_time    = waiting;
          result_next.response_time   = response;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      current_time <= '0;
      done         <= 1'b0;
      pend         <= 1'b0;
      found        <= 1'b0;
      iss          <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.opcode == OP_LOAD) begin
              done   <= 1'b1;
              result <= result_next;
              if (!full) begin
                loaded_count <= loaded_count + 1'b1;
              end
            end else begin
              iss   <= '0;
              pend  <= 1'b0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend     <= rd_en;
          pend_idx <= iss[SLOT_BITS-1:0];
          if (rd_en) begin
            iss <= iss + 1'b1;
          end
          if (ready_cand && better) begin
            found    <= 1'b1;
            best     <= rd_data;
            best_idx <= pend_idx;
          end
          if (scan_last) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          current_time <= time_adv;
          result       <= result_next;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pps_checker.sv -----
// Port-level checks for the preemptive priority scheduler, bound to the top.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_checker
  import pps_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input res_t result
);

  // A load word answers in the next cycle with a load status
  a_load_resp: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.opcode == OP_LOAD) |=>
      done && ((result.status == ST_LOADED) || (result.status == ST_FULL)))
    else $error("load word not answered next cycle");

  // A tick word holds the block busy while the table is scanned
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.opcode == OP_TICK) |=> busy && !done)
    else $error("tick word did not start a scan");

  // Timing figures only on a finishing word
  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.finished |->
      (result.start_time == '0) && (result.completion_time == '0) &&
      (result.turnaround_time == '0) && (result.waiting_time == '0) &&
      (result.response_time == '0))
    else $error("timing figures set on an unfinished word");

  // A finishing word names a process that ran
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    done && result.finished |->
      (result.status == ST_RAN) && (result.process_number != '0))
    else $error("finished word without a running process");

  // Idle ticks and rejected loads name no process
  a_no_proc: assert property (@(posedge clk) disable iff (rst)
    done && ((result.status == ST_IDLE) || (result.status == ST_FULL)) |->
      (result.process_number == '0) && !result.finished)
    else $error("process number on idle or rejected word");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
